@@ hdl/s8fp_pkg.sv @@
// Shared types and constants of the sum8 frame parser.
// Used by s8fp_parser, s8fp_outq and sum8_frame_parser_top.
package s8fp_pkg;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_MODE = 3'd1,
		PH_LEN  = 3'd2,
		PH_CMD  = 3'd3,
		PH_PAY  = 3'd4,
		PH_CHK  = 3'd5,
		PH_DROP = 3'd6,
		PH_BAD  = 3'd7
	} phase_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_START = 3'd1;
	localparam logic [2:0] ST_CHECKSUM  = 3'd2;
	localparam logic [2:0] ST_TRUNCATED = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd4;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	localparam logic CFG_START_OF_FRAME = 1'b0;
	localparam logic CFG_READY_COMMAND  = 1'b1;

	// header bytes before the payload: start, mode, length, command
	localparam logic [7:0] HDR_BYTES = 8'd4;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_burst;
	} in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] command;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [2:0] status;
		logic       last;
	} out_t;

	typedef struct packed {
		logic [7:0] start_of_frame;
		logic [7:0] ready_command;
	} cfg_t;

	// up to two result words pushed per parsed byte
	typedef struct packed {
		logic [1:0] cnt;
		out_t       d0;
		out_t       d1;
	} push_t;

endpackage

@@ hdl/s8fp_outq.sv @@
// Result queue of the sum8 frame parser: four words, two writes and one read a cycle.
// Depends on s8fp_pkg.
module s8fp_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  s8fp_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output s8fp_pkg::out_t result
);
	import s8fp_pkg::*;

	localparam int CW = $clog2(OQ_DEPTH + 1);

	out_t            mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign result    = mem_q[rptr_q];
	assign pop       = out_valid && out_ready;
	// accept a new byte only when both words of its worst case fit
	assign room      = (count_q <= CW'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wptr_q] <= push.d0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wptr_q + OQ_AW'(1)] <= push.d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + OQ_AW'(push.cnt);
			if (pop) begin
				rptr_q <= rptr_q + OQ_AW'(1);
			end
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(OQ_DEPTH))
		else $error("result queue over capacity");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> (count_q + CW'(push.cnt) <= CW'(OQ_DEPTH)))
		else $error("push into full result queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd0 && !pop) |=> $stable(count_q))
		else $error("queue count moved without push or pop");

endmodule

@@ hdl/s8fp_parser.sv @@
// Byte parser of the sum8 frame parser: input register, frame state machine, result words.
// Depends on s8fp_pkg.
module s8fp_parser #(
	parameter int MAX_BURST = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  s8fp_pkg::in_t   in_data,
	input  s8fp_pkg::cfg_t  cfg,
	input  logic            room,
	output s8fp_pkg::push_t push
);
	import s8fp_pkg::*;

	localparam int BW = $clog2(MAX_BURST + 1);

	logic          valid_s1;
	in_t           data_s1;
	logic          go, take;

	phase_t        phase_q, phase_step, phase_d;
	logic [7:0]    sum_q, sum_d;
	logic [7:0]    left_q, left_d;
	logic [7:0]    cmd_q, cmd_step, cmd_d;
	logic [7:0]    cnt_q, cnt_d;
	logic [BW-1:0] burst_q, burst_d;
	logic          ready_q, ready_d;

	logic          a_v, b_v;
	out_t          res_a, res_b;
	logic [7:0]    b;
	logic [7:0]    bad_cnt;

	assign b        = data_s1.rx_byte;
	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || go;
	assign take     = go && (burst_q < BW'(MAX_BURST));
	assign bad_cnt  = cnt_q + 8'd1;

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_HUNT;
			sum_q    <= '0;
			left_q   <= '0;
			cmd_q    <= '0;
			cnt_q    <= '0;
			burst_q  <= '0;
			ready_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				phase_q <= phase_d;
				sum_q   <= sum_d;
				left_q  <= left_d;
				cmd_q   <= cmd_d;
				cnt_q   <= cnt_d;
				burst_q <= burst_d;
				ready_q <= ready_d;
			end
		end
	end

	// next state
	always_comb begin
		phase_step = phase_q;
		sum_d      = sum_q;
		left_d     = left_q;
		cmd_step   = cmd_q;
		cnt_d      = cnt_q;
		burst_d    = burst_q;
		ready_d    = ready_q;
		if (take) begin
			burst_d = burst_q + BW'(1);
			unique case (phase_q)
				PH_HUNT: begin
					sum_d      = b;
					cnt_d      = 8'd1;
					phase_step = (b == cfg.start_of_frame) ? PH_MODE : PH_BAD;
				end
				PH_MODE: begin
					sum_d      = sum_q + b;
					cnt_d      = 8'd2;
					phase_step = PH_LEN;
				end
				PH_LEN: begin
					sum_d      = sum_q + b;
					left_d     = b;
					cnt_d      = 8'd3;
					phase_step = PH_CMD;
				end
				PH_CMD: begin
					sum_d    = sum_q + b;
					cmd_step = b;
					cnt_d    = 8'd0;
					if (left_q == 8'd0) begin
						phase_step = PH_DROP;
					end else begin
						left_d     = left_q - 8'd1;
						phase_step = (left_q != 8'd1) ? PH_PAY : PH_CHK;
					end
				end
				PH_PAY: begin
					sum_d  = sum_q + b;
					cnt_d  = cnt_q + 8'd1;
					left_d = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_step = PH_CHK;
					end
				end
				PH_CHK: begin
					if (b == sum_q) begin
						if (cmd_q == cfg.ready_command) begin
							ready_d = 1'b1;
						end
						phase_step = PH_HUNT;
					end else begin
						phase_step = PH_DROP;
					end
					sum_d = 8'd0;
					cnt_d = 8'd0;
				end
				PH_BAD: begin
					cnt_d = bad_cnt;
					if (bad_cnt >= HDR_BYTES) begin
						phase_step = PH_DROP;
					end
				end
				PH_DROP: begin
				end
				default: begin
				end
			endcase
		end
		phase_d = phase_step;
		cmd_d   = cmd_step;
		// end of burst: back to hunting, partner state kept
		if (go && data_s1.end_of_burst) begin
			phase_d = PH_HUNT;
			sum_d   = 8'd0;
			left_d  = 8'd0;
			cmd_d   = 8'd0;
			cnt_d   = 8'd0;
			burst_d = '0;
		end
	end

	// result words
	always_comb begin
		a_v   = 1'b0;
		res_a = '0;
		if (take) begin
			unique case (phase_q)
				PH_CMD: begin
					if (left_q == 8'd0) begin
						a_v           = 1'b1;
						res_a.kind    = KIND_REPORT;
						res_a.command = b;
						res_a.status  = ST_ZERO_LEN;
					end
				end
				PH_PAY: begin
					a_v                 = 1'b1;
					res_a.kind          = KIND_PAYLOAD;
					res_a.command       = cmd_q;
					res_a.payload_byte  = b;
					res_a.payload_index = cnt_q;
					res_a.status        = ST_OK;
				end
				PH_CHK: begin
					a_v           = 1'b1;
					res_a.kind    = KIND_REPORT;
					res_a.command = cmd_q;
					res_a.status  = (b == sum_q) ? ST_OK : ST_CHECKSUM;
				end
				PH_BAD: begin
					if (bad_cnt >= HDR_BYTES && ready_q) begin
						a_v          = 1'b1;
						res_a.kind   = KIND_REPORT;
						res_a.status = ST_BAD_START;
					end
				end
				PH_HUNT, PH_MODE, PH_LEN, PH_DROP: begin
				end
				default: begin
				end
			endcase
		end

		b_v = go && data_s1.end_of_burst &&
			(phase_step == PH_PAY || phase_step == PH_CHK);
		res_b         = '0;
		res_b.kind    = KIND_REPORT;
		res_b.command = cmd_step;
		res_b.status  = ST_TRUNCATED;
		res_b.last    = 1'b1;

		push.cnt     = {1'b0, a_v} + {1'b0, b_v};
		push.d0      = a_v ? res_a : res_b;
		push.d0.last = !(a_v && b_v);
		push.d1      = res_b;
	end

	a_drop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(go && phase_q == PH_DROP && !data_s1.end_of_burst) |-> (push.cnt == 2'd0))
		else $error("result word while dropping");
	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |=> ready_q)
		else $error("partner ready cleared");
	a_burst_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(go && data_s1.end_of_burst) |=> (burst_q == '0 && phase_q == PH_HUNT))
		else $error("burst state not cleared at end of burst");
	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!go |-> (push.cnt == 2'd0))
		else $error("result word without a byte");

endmodule

@@ hdl/sum8_frame_parser_top.sv @@
// Top level of the sum8 frame parser: configuration registers, parser and result queue.
// Depends on s8fp_pkg, s8fp_parser and s8fp_outq.
// A byte is registered at the parser input, then its result words in the result queue.
// Throughput: one byte per cycle; a byte may give two words, which a four-word result queue
// drains one per cycle while out_ready is high; it pauses input only when nearly full.
// Reset: asynchronous; parser hunts for a start byte, registers and partner ready clear.
module sum8_frame_parser_top #(
	parameter int MAX_BURST = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  s8fp_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output s8fp_pkg::out_t result,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data
);
	import s8fp_pkg::*;

	cfg_t  cfg_q;
	push_t push;
	logic  room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_OF_FRAME: cfg_q.start_of_frame <= cfg_data;
				CFG_READY_COMMAND:  cfg_q.ready_command  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	s8fp_parser #(
		.MAX_BURST(MAX_BURST)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.room     (room),
		.push     (push)
	);

	s8fp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(result)))
		else $error("result word changed while stalled");
	a_in_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("push without room");
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == CFG_READY_COMMAND) |=> (cfg_q.ready_command == $past(cfg_data)))
		else $error("ready command not written");

endmodule
